// File: rtl/tle_pkg.sv
// Shared types, codes and echo-sequence functions for the terminal line editor.
package tle_pkg;

   localparam int POS_W = 8;
   localparam int IDX_W = 3;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [7:0]       byte_type;

   // request kinds
   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // result kinds
   localparam logic [1:0] RK_ECHO = 2'd0;
   localparam logic [1:0] RK_LINE = 2'd1;
   localparam logic [1:0] RK_READ = 2'd2;
   localparam logic [1:0] RK_DROP = 2'd3;

   // terminal bytes
   localparam byte_type CH_NUL      = 8'd0;
   localparam byte_type CH_TAB      = 8'd9;
   localparam byte_type CH_LF       = 8'd10;
   localparam byte_type CH_CR       = 8'd13;
   localparam byte_type CH_ESC      = 8'd27;
   localparam byte_type CH_ONE      = 8'd49;
   localparam byte_type CH_AT       = 8'd64;
   localparam byte_type CH_C        = 8'd67;
   localparam byte_type CH_D        = 8'd68;
   localparam byte_type CH_P        = 8'd80;
   localparam byte_type CH_LBRACKET = 8'd91;
   localparam byte_type CH_DEL_AT   = 8'd126;
   localparam byte_type CH_DEL_BACK = 8'd127;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      pos_type     pos;
      byte_type    ch;
   } row_ctrl_type;

   typedef enum logic [3:0] {
      SEQ_ESC_D     = 4'd0,
      SEQ_ESC_C     = 4'd1,
      SEQ_ESC_P     = 4'd2,
      SEQ_BACKSPACE = 4'd3,
      SEQ_INSERT    = 4'd4,
      SEQ_ENTER     = 4'd5,
      SEQ_DROP      = 4'd6,
      SEQ_READ      = 4'd7
   } seq_type;

   function automatic idx_type seq_last(seq_type s);
      case (s)
         SEQ_ESC_D, SEQ_ESC_C, SEQ_ESC_P: seq_last = 3'd3;
         SEQ_BACKSPACE:                   seq_last = 3'd7;
         SEQ_INSERT:                      seq_last = 3'd4;
         SEQ_ENTER:                       seq_last = 3'd1;
         default:                         seq_last = 3'd0;
      endcase
   endfunction

   // ESC [ 1 code
   function automatic byte_type esc_byte(logic [1:0] i, byte_type code);
      case (i)
         2'd0:    esc_byte = CH_ESC;
         2'd1:    esc_byte = CH_LBRACKET;
         2'd2:    esc_byte = CH_ONE;
         default: esc_byte = code;
      endcase
   endfunction

   function automatic byte_type seq_data(seq_type s, idx_type i, byte_type ch, byte_type rd);
      case (s)
         SEQ_ESC_D:     seq_data = esc_byte(i[1:0], CH_D);
         SEQ_ESC_C:     seq_data = esc_byte(i[1:0], CH_C);
         SEQ_ESC_P:     seq_data = esc_byte(i[1:0], CH_P);
         SEQ_BACKSPACE: seq_data = esc_byte(i[1:0], i[2] ? CH_P : CH_D);
         SEQ_INSERT:    seq_data = i[2] ? ch : esc_byte(i[1:0], CH_AT);
         SEQ_ENTER:     seq_data = (i == 3'd0) ? CH_LF : CH_NUL;
         SEQ_DROP:      seq_data = ch;
         SEQ_READ:      seq_data = rd;
         default:       seq_data = CH_NUL;
      endcase
   endfunction

   function automatic logic [1:0] seq_kind(seq_type s, idx_type i);
      case (s)
         SEQ_ENTER: seq_kind = (i == 3'd1) ? RK_LINE : RK_ECHO;
         SEQ_DROP:  seq_kind = RK_DROP;
         SEQ_READ:  seq_kind = RK_READ;
         default:   seq_kind = RK_ECHO;
      endcase
   endfunction

endpackage

// File: rtl/tle_cell.sv
// One character cell of the line store; shifts with its neighbors on insert and delete.
module tle_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  tle_pkg::row_ctrl_type ctrl,
   input  tle_pkg::byte_type     left_ch,
   input  tle_pkg::byte_type     right_ch,
   input  tle_pkg::pos_type      rd_pos,
   output tle_pkg::byte_type     ch,
   output tle_pkg::byte_type     rd_byte
);

   localparam tle_pkg::pos_type MY_POS = tle_pkg::pos_type'(IDX);

   tle_pkg::byte_type ch_ff, ch_in;
   tle_pkg::byte_type rd_ff, rd_in;

   always_comb begin
      ch_in = ch_ff;
      case (ctrl.op)
         tle_pkg::OP_INSERT: begin
            if (MY_POS == ctrl.pos) begin
               ch_in = ctrl.ch;
            end else if (MY_POS > ctrl.pos) begin
               ch_in = left_ch;
            end
         end
         tle_pkg::OP_DELETE: begin
            if (MY_POS >= ctrl.pos) begin
               ch_in = right_ch;
            end
         end
         default: ch_in = ch_ff;
      endcase
      // gated copy feeds the read OR tree
      rd_in = (rd_pos == MY_POS) ? ch_ff : '0;
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      rd_ff <= rd_in;
   end

   assign ch      = ch_ff;
   assign rd_byte = rd_ff;

endmodule

// File: rtl/tle_row.sv
// Row of character cells plus a registered OR tree for indexed reads.
module tle_row #(
   parameter int LINE_MAX = 80
) (
   input  logic                  clock,
   input  tle_pkg::row_ctrl_type ctrl,
   input  tle_pkg::pos_type      rd_pos,
   output tle_pkg::byte_type     rd_data
);

   localparam int GROUPS = (LINE_MAX + 7) / 8;

   tle_pkg::byte_type ch_w [LINE_MAX];
   tle_pkg::byte_type rd_w [LINE_MAX];
   tle_pkg::byte_type grp_ff [GROUPS];
   tle_pkg::byte_type grp_in [GROUPS];
   tle_pkg::byte_type out_ff, out_in;

   for (genvar i = 0; i < LINE_MAX; i++) begin : g_cell
      tle_pkg::byte_type left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = tle_pkg::CH_NUL;
      end else begin : g_mid_l
         assign left_w = ch_w[i-1];
      end
      if (i == LINE_MAX - 1) begin : g_last
         assign right_w = ch_w[i];
      end else begin : g_mid_r
         assign right_w = ch_w[i+1];
      end
      tle_cell #(.IDX(i)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .left_ch  (left_w),
         .right_ch (right_w),
         .rd_pos   (rd_pos),
         .ch       (ch_w[i]),
         .rd_byte  (rd_w[i])
      );
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < 8; k++) begin
            if (g * 8 + k < LINE_MAX) begin
               grp_in[g] = grp_in[g] | rd_w[g * 8 + k];
            end
         end
      end
      out_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         out_in = out_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      out_ff <= out_in;
   end

   assign rd_data = out_ff;

endmodule

// File: rtl/terminal_line_editor.sv
// Terminal line editor top level: byte decode, cursor/length control, result sequencer.
// Edits: an edit shows its first result in the cycle after the item is accepted;
//   a read passes the read position register and the row's cell gate, group OR and
//   final OR registers before its result shows. Items are taken one at a time: a new
//   item waits until the result sequencer has emitted every result of the last one.
// Reset: synchronous, active high; clears cursor, length, escape and hold flags
//   and the sequencer. Line store cells are not reset (unreadable until written).
module terminal_line_editor #(
   parameter int LINE_MAX = 80
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_rx_byte,
   input  logic [6:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic [6:0] rsp_line_length,
   output logic [6:0] rsp_cursor_pos,
   output logic       rsp_last_of_run
);

   localparam tle_pkg::pos_type LINE_MAX_POS = tle_pkg::pos_type'(LINE_MAX);
   localparam logic [1:0]       READ_WAIT    = 2'd2;  // row read pipeline depth minus one

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   tle_pkg::pos_type  cursor_ff, cursor_in;
   tle_pkg::pos_type  length_ff, length_in;
   logic              esc_ff, esc_in;
   logic              held_ff, held_in;
   tle_pkg::seq_type  seq_ff, seq_in;
   tle_pkg::idx_type  idx_ff, idx_in;
   tle_pkg::byte_type ch_ff, ch_in;
   tle_pkg::pos_type  rd_pos_ff, rd_pos_in;
   logic              rd_hit_ff, rd_hit_in;
   logic [1:0]        wait_ff, wait_in;

   tle_pkg::row_ctrl_type ctrl;
   tle_pkg::byte_type     rd_data;
   tle_pkg::pos_type      req_pos;
   logic                  req_acc;
   logic                  rsp_acc;
   logic                  last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign last      = (idx_ff == tle_pkg::seq_last(seq_ff));
   assign req_pos   = {{(tle_pkg::POS_W - 7){1'b0}}, req_read_index};

   // ------------------------------------------------------------------
   // Decode: state and line store update at the accept edge; the results
   // that follow all carry the updated cursor and length.
   // ------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      length_in = length_ff;
      esc_in    = esc_ff;
      held_in   = held_ff;
      seq_in    = seq_ff;
      idx_in    = idx_ff;
      ch_in     = ch_ff;
      rd_pos_in = rd_pos_ff;
      rd_hit_in = rd_hit_ff;
      wait_in   = wait_ff;
      ctrl.op   = tle_pkg::OP_NONE;
      ctrl.pos  = cursor_ff;
      ctrl.ch   = req_rx_byte;

      case (state_ff)
         ST_IDLE: begin
            idx_in  = '0;
            wait_in = '0;
            ch_in   = req_rx_byte;
            if (req_acc) begin
               case (req_kind)
                  tle_pkg::REQ_BYTE: begin
                     if (held_ff) begin
                        seq_in   = tle_pkg::SEQ_DROP;
                        state_in = ST_EMIT;
                     end else if (req_rx_byte == tle_pkg::CH_ESC ||
                                  (esc_ff && req_rx_byte == tle_pkg::CH_LBRACKET)) begin
                        esc_in = 1'b1;
                     end else if (req_rx_byte == tle_pkg::CH_NUL) begin
                        // NUL is dropped silently and keeps a pending escape
                        esc_in = esc_ff;
                     end else if (esc_ff) begin
                        esc_in = 1'b0;
                        if (req_rx_byte == tle_pkg::CH_D && cursor_ff != '0) begin
                           cursor_in = cursor_ff - 1'b1;
                           seq_in    = tle_pkg::SEQ_ESC_D;
                           state_in  = ST_EMIT;
                        end else if (req_rx_byte == tle_pkg::CH_C && cursor_ff < length_ff) begin
                           cursor_in = cursor_ff + 1'b1;
                           seq_in    = tle_pkg::SEQ_ESC_C;
                           state_in  = ST_EMIT;
                        end
                     end else begin
                        case (req_rx_byte)
                           tle_pkg::CH_CR: begin
                              held_in  = 1'b1;
                              seq_in   = tle_pkg::SEQ_ENTER;
                              state_in = ST_EMIT;
                           end
                           tle_pkg::CH_DEL_AT: begin
                              if (cursor_ff < length_ff) begin
                                 ctrl.op   = tle_pkg::OP_DELETE;
                                 length_in = length_ff - 1'b1;
                                 seq_in    = tle_pkg::SEQ_ESC_P;
                                 state_in  = ST_EMIT;
                              end
                           end
                           tle_pkg::CH_DEL_BACK: begin
                              if (cursor_ff != '0) begin
                                 ctrl.op   = tle_pkg::OP_DELETE;
                                 ctrl.pos  = cursor_ff - 1'b1;
                                 cursor_in = cursor_ff - 1'b1;
                                 length_in = length_ff - 1'b1;
                                 seq_in    = tle_pkg::SEQ_BACKSPACE;
                                 state_in  = ST_EMIT;
                              end
                           end
                           tle_pkg::CH_TAB: begin
                              esc_in = 1'b0;
                           end
                           default: begin
                              if (length_ff < LINE_MAX_POS && cursor_ff <= length_ff) begin
                                 ctrl.op   = tle_pkg::OP_INSERT;
                                 cursor_in = cursor_ff + 1'b1;
                                 length_in = length_ff + 1'b1;
                                 seq_in    = tle_pkg::SEQ_INSERT;
                                 state_in  = ST_EMIT;
                              end
                           end
                        endcase
                     end
                  end
                  tle_pkg::REQ_READ: begin
                     rd_pos_in = req_pos;
                     rd_hit_in = (req_pos < length_ff);
                     seq_in    = tle_pkg::SEQ_READ;
                     state_in  = ST_READ;
                  end
                  tle_pkg::REQ_RELEASE: begin
                     if (held_ff) begin
                        held_in   = 1'b0;
                        cursor_in = '0;
                        length_in = '0;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == READ_WAIT) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 1'b1;
               if (last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         length_ff <= '0;
         esc_ff    <= 1'b0;
         held_ff   <= 1'b0;
         idx_ff    <= '0;
         wait_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         length_ff <= length_in;
         esc_ff    <= esc_in;
         held_ff   <= held_in;
         idx_ff    <= idx_in;
         wait_ff   <= wait_in;
      end
      seq_ff    <= seq_in;
      ch_ff     <= ch_in;
      rd_pos_ff <= rd_pos_in;
      rd_hit_ff <= rd_hit_in;
   end

   // line store: chain of cells
   tle_row #(.LINE_MAX(LINE_MAX)) u_row (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_pos  (rd_pos_ff),
      .rd_data (rd_data)
   );

   // result fields are decoded from registered sequencer state
   assign rsp_result_kind = tle_pkg::seq_kind(seq_ff, idx_ff);
   assign rsp_data_byte   = tle_pkg::seq_data(seq_ff, idx_ff, ch_ff,
                                              rd_hit_ff ? rd_data : tle_pkg::CH_NUL);
   assign rsp_line_length = length_ff[6:0];
   assign rsp_cursor_pos  = cursor_ff[6:0];
   assign rsp_last_of_run = last;

`ifndef ASSERT_OFF
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= length_ff)
      else $error("cursor beyond line length");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LINE_MAX_POS)
      else $error("line length beyond capacity");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> idx_ff <= tle_pkg::seq_last(seq_ff))
      else $error("result index past end of sequence");

   a_read_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && wait_ff == READ_WAIT) |=> rsp_valid)
      else $error("read result not presented after row pipeline");
`endif

endmodule

// File: test/terminal_line_editor_test.sv
// Self-checking testbench for the terminal line editor: directed table, then random edit traffic.
module terminal_line_editor_test;
   import tle_pkg::*;

   localparam int LINE_CAP    = 80;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block
   localparam int PHASE_ITEMS = 112;   // random items per phase
   localparam int TAIL_CYCLES = 16;    // covers read latency and no-result items

   // kind 3 is not a request the block knows; it must be ignored
   localparam logic [1:0] REQ_IGNORED = 2'd3;

   // how a stimulus row gets its expected results
   localparam int BY_MODEL   = -1;     // from the predictor
   localparam int TYPED_NONE = 0;      // typed in: no result at all
   localparam int TYPED_ONE  = 1;      // typed in: exactly one result

   typedef struct packed {
      logic [1:0] kind;
      byte_type   data;
      logic [6:0] len;
      logic [6:0] cur;
      logic       last;
   } rsp_rec_t;

   typedef struct {
      logic [1:0] kind;
      byte_type   rx;
      logic [6:0] idx;
      int         n_typed;
      rsp_rec_t   want;
   } stim_t;

   localparam rsp_rec_t NO_RES = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind = REQ_BYTE;
   logic [7:0] req_rx_byte = '0;
   logic [6:0] req_read_index = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_data_byte;
   logic [6:0] rsp_line_length;
   logic [6:0] rsp_cursor_pos;
   logic       rsp_last_of_run;

   terminal_line_editor #(.LINE_MAX(LINE_CAP)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_rx_byte     (req_rx_byte),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_line_length (rsp_line_length),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Editor predictor: own copy of line, cursor, length and flags.
   // ---------------------------------------------------------------
   byte_type line_mem [LINE_CAP];
   int       cur_q;
   int       len_q;
   bit       esc_armed;
   bit       held;

   rsp_rec_t echo_buf [8];   // results of the item being predicted
   int       echo_n;

   rsp_rec_t predicted_q [$]; // results owed by the block, oldest first
   int       errors;

   // idling knobs, percent of cycles
   int       send_idle_pct;
   int       rsp_stall_pct;
   bit       hold_req;
   int       hold_cnt;
   int       fill_left;       // forced inserts to push the line to full

   function automatic void add_res(logic [1:0] k, byte_type d);
      echo_buf[echo_n] = '{kind: k, data: d, len: '0, cur: '0, last: 1'b0};
      echo_n++;
   endfunction

   // ESC [ 1 code
   function automatic void add_esc(byte_type code);
      add_res(RK_ECHO, CH_ESC);
      add_res(RK_ECHO, CH_LBRACKET);
      add_res(RK_ECHO, CH_ONE);
      add_res(RK_ECHO, code);
   endfunction

   function automatic void drop_char(int where);
      int i;
      if (where < len_q) begin
         for (i = where; i + 1 < len_q; i++) line_mem[i] = line_mem[i + 1];
         len_q--;
      end
   endfunction

   task automatic step_editor(input logic [1:0] kind, input byte_type c, input logic [6:0] idx);
      bit escaped;
      int i;
      echo_n = 0;
      case (kind)
         REQ_BYTE: begin
            if (held) begin
               add_res(RK_DROP, c);
            end else if (c == CH_ESC || (esc_armed && c == CH_LBRACKET)) begin
               esc_armed = 1'b1;
            end else if (c != CH_NUL) begin
               // NUL falls through above and keeps a pending escape
               escaped   = esc_armed;
               esc_armed = 1'b0;
               if (escaped) begin
                  if (c == CH_D && cur_q > 0) begin
                     cur_q--;
                     add_esc(CH_D);
                  end else if (c == CH_C && cur_q < len_q) begin
                     cur_q++;
                     add_esc(CH_C);
                  end
               end else if (c == CH_CR) begin
                  add_res(RK_ECHO, CH_LF);
                  add_res(RK_LINE, CH_NUL);
                  held = 1'b1;
               end else if (c == CH_DEL_AT) begin
                  if (cur_q < len_q) begin
                     drop_char(cur_q);
                     add_esc(CH_P);
                  end
               end else if (c == CH_DEL_BACK) begin
                  if (cur_q > 0) begin
                     add_esc(CH_D);
                     add_esc(CH_P);
                     drop_char(cur_q - 1);
                     cur_q--;
                  end
               end else if (c == CH_TAB) begin
                  // tab: nothing
               end else if (len_q < LINE_CAP && cur_q <= len_q) begin
                  for (i = len_q; i > cur_q; i--) line_mem[i] = line_mem[i - 1];
                  line_mem[cur_q] = c;
                  cur_q++;
                  len_q++;
                  add_esc(CH_AT);
                  add_res(RK_ECHO, c);
               end
            end
         end
         REQ_READ: begin
            // beyond the length reads zero, so unwritten cells never show
            add_res(RK_READ, (int'(idx) < len_q) ? line_mem[idx] : CH_NUL);
         end
         REQ_RELEASE: begin
            if (held) begin
               held  = 1'b0;
               cur_q = 0;
               len_q = 0;
            end
         end
         default: begin
         end
      endcase
      // every result carries length and cursor after the whole item
      for (i = 0; i < echo_n; i++) begin
         echo_buf[i].len  = 7'(len_q);
         echo_buf[i].cur  = 7'(cur_q);
         echo_buf[i].last = (i == echo_n - 1);
      end
   endtask

   // ---------------------------------------------------------------
   // Stimulus rows
   // ---------------------------------------------------------------
   function automatic rsp_rec_t res(logic [1:0] k, byte_type d, int len, int cur);
      res = '{kind: k, data: d, len: 7'(len), cur: 7'(cur), last: 1'b1};
   endfunction

   function automatic stim_t row(logic [1:0] k, byte_type c, logic [6:0] ix, int n,
                                 rsp_rec_t r);
      row = '{kind: k, rx: c, idx: ix, n_typed: n, want: r};
   endfunction

   // Random item, shaped by the predicted state so that most traffic is
   // editing a live line: inserts, escape moves, deletes, Enter, reads.
   function automatic stim_t pick_item();
      int       r;
      byte_type c;
      logic [6:0] junk_idx;
      byte_type   junk_rx;
      r        = $urandom_range(99);
      junk_idx = 7'($urandom_range(127));
      junk_rx  = 8'($urandom_range(255));
      if (fill_left > 0 && !held) begin
         fill_left--;
         return row(REQ_BYTE, 8'($urandom_range(125, 32)), junk_idx, BY_MODEL, NO_RES);
      end
      if (held) begin
         if (r < 55) begin
            if ($urandom_range(3) == 0)
               return row(REQ_READ, junk_rx, 7'($urandom_range(127)), BY_MODEL, NO_RES);
            return row(REQ_READ, junk_rx, 7'($urandom_range(len_q)), BY_MODEL, NO_RES);
         end
         if (r < 80) return row(REQ_RELEASE, junk_rx, junk_idx, BY_MODEL, NO_RES);
         if (r < 95) return row(REQ_BYTE, junk_rx, junk_idx, BY_MODEL, NO_RES);
         return row(REQ_IGNORED, junk_rx, junk_idx, BY_MODEL, NO_RES);
      end
      if (esc_armed && r < 75) begin
         case ($urandom_range(9))
            0, 1, 2, 3: c = CH_C;
            4, 5, 6:    c = CH_D;
            7:          c = CH_LBRACKET;
            8:          c = CH_NUL;
            default:    c = junk_rx;
         endcase
         return row(REQ_BYTE, c, junk_idx, BY_MODEL, NO_RES);
      end
      r = $urandom_range(99);
      if (r < 40)      c = 8'($urandom_range(125, 32));
      else if (r < 50) c = junk_rx;
      else if (r < 62) c = CH_ESC;
      else if (r < 70) c = CH_DEL_BACK;
      else if (r < 76) c = CH_DEL_AT;
      else if (r < 79) c = CH_CR;
      else if (r < 82) c = CH_TAB;
      else begin
         if (r < 90) return row(REQ_READ, junk_rx, 7'($urandom_range(len_q)), BY_MODEL, NO_RES);
         if (r < 95) return row(REQ_RELEASE, junk_rx, junk_idx, BY_MODEL, NO_RES);
         return row(REQ_IGNORED, junk_rx, junk_idx, BY_MODEL, NO_RES);
      end
      return row(REQ_BYTE, c, junk_idx, BY_MODEL, NO_RES);
   endfunction

   // ---------------------------------------------------------------
   // Input side: present one item, hold it until taken, then predict.
   // Called in a clock-edge step; leaves valid high for a back-to-back item.
   // ---------------------------------------------------------------
   task automatic offer(input stim_t s);
      int i;
      req_valid      <= 1'b1;
      req_kind       <= s.kind;
      req_rx_byte    <= s.rx;
      req_read_index <= s.idx;
      do @(posedge clock); while (req_ready !== 1'b1);
      step_editor(s.kind, s.rx, s.idx);
      if (s.n_typed == BY_MODEL) begin
         for (i = 0; i < echo_n; i++) predicted_q.push_back(echo_buf[i]);
      end else if (s.n_typed == TYPED_ONE) begin
         predicted_q.push_back(s.want);
      end
   endtask

   task automatic idle_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // sender stops and waits for every owed result, plus the tail
   task automatic drain();
      req_valid <= 1'b0;
      while (predicted_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Output side: compare each taken result with the oldest prediction.
   // ---------------------------------------------------------------
   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_result();
      rsp_rec_t want;
      if (predicted_q.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual kind %0d data %0d",
                  $time, rsp_result_kind, rsp_data_byte);
         errors++;
         return;
      end
      want = predicted_q.pop_front();
      check_field("result_kind", 8'(want.kind), 8'(rsp_result_kind));
      check_field("data_byte",   want.data,     rsp_data_byte);
      check_field("line_length", 8'(want.len),  8'(rsp_line_length));
      check_field("cursor_pos",  8'(want.cur),  8'(rsp_cursor_pos));
      check_field("last_of_run", 8'(want.last), 8'(rsp_last_of_run));
   endfunction

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) check_result();
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_cnt  = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // generous fixed limit
   initial begin
      #2_000_000;
      $display("terminal_line_editor regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      stim_t dir_tab [$];
      int    ph;
      int    done;

      errors        = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req      = 1'b0;
      hold_cnt      = 0;
      fill_left     = 0;
      cur_q         = 0;
      len_q         = 0;
      esc_armed     = 1'b0;
      held          = 1'b0;
      foreach (line_mem[i]) line_mem[i] = '0;

      // Directed table. Unused fields carry junk on purpose.
      // reads on an empty line, ignored release and kind, no-op edits
      dir_tab.push_back(row(REQ_READ, 8'hff, 7'd0, TYPED_ONE, res(RK_READ, CH_NUL, 0, 0)));
      dir_tab.push_back(row(REQ_READ, 8'h00, 7'd127, TYPED_ONE, res(RK_READ, CH_NUL, 0, 0)));
      dir_tab.push_back(row(REQ_RELEASE, 8'hff, 7'd127, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_IGNORED, 8'hff, 7'd127, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_DEL_BACK, 7'd127, TYPED_NONE, NO_RES));
      // ESC D with cursor at 0: no move
      dir_tab.push_back(row(REQ_BYTE, CH_ESC, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_D, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_TAB, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_NUL, 7'd0, TYPED_NONE, NO_RES));
      // three inserts, byte extremes among them
      dir_tab.push_back(row(REQ_BYTE, 8'd97, 7'd0, BY_MODEL, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, 8'd255, 7'd0, BY_MODEL, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, 8'd1, 7'd0, BY_MODEL, NO_RES));
      // ESC [ D moves left
      dir_tab.push_back(row(REQ_BYTE, CH_ESC, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_LBRACKET, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_D, 7'd0, BY_MODEL, NO_RES));
      // NUL between ESC and D keeps the escape armed
      dir_tab.push_back(row(REQ_BYTE, CH_ESC, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_NUL, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_D, 7'd0, BY_MODEL, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_ESC, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_C, 7'd0, BY_MODEL, NO_RES));
      // escaped byte other than C/D is swallowed
      dir_tab.push_back(row(REQ_BYTE, CH_ESC, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, 8'd88, 7'd0, TYPED_NONE, NO_RES));
      // backspace, delete at cursor, Enter; line is now "a", cursor 1
      dir_tab.push_back(row(REQ_BYTE, CH_DEL_BACK, 7'd0, BY_MODEL, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_DEL_AT, 7'd0, BY_MODEL, NO_RES));
      dir_tab.push_back(row(REQ_BYTE, CH_CR, 7'd0, BY_MODEL, NO_RES));
      // bytes on a held line are dropped, ESC too
      dir_tab.push_back(row(REQ_BYTE, 8'd122, 7'd0, TYPED_ONE, res(RK_DROP, 8'd122, 1, 1)));
      dir_tab.push_back(row(REQ_BYTE, CH_ESC, 7'd0, TYPED_ONE, res(RK_DROP, CH_ESC, 1, 1)));
      dir_tab.push_back(row(REQ_READ, 8'd0, 7'd0, BY_MODEL, NO_RES));
      dir_tab.push_back(row(REQ_RELEASE, 8'd0, 7'd0, TYPED_NONE, NO_RES));
      dir_tab.push_back(row(REQ_RELEASE, 8'd0, 7'd0, TYPED_NONE, NO_RES));

      // single reset at the start
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) offer(dir_tab[i]);
      drain();

      // Random phases: no idling, sender idle, receiver stalls, both.
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         // one run of inserts past the line limit in this phase
         if (ph == 1) fill_left = LINE_CAP + 6;
         done = 0;
         while (done < PHASE_ITEMS) begin
            idle_gap();
            offer(pick_item());
            done++;
            // receiver holds off while the sender keeps offering
            if (ph == 0 && done == 40) hold_req = 1'b1;
         end
         drain();
      end

      if (errors == 0 && predicted_q.size() == 0) begin
         $display("terminal_line_editor regression: pass");
      end else begin
         $display("terminal_line_editor regression: fail");
      end
      $finish;
   end

endmodule
